// ----- hdl/shpf_pkg.sv -----
// ----------------------------------------------------------------------------
// shpf_pkg
// Shared types and constants of the slice histogram peak finder.
// ----------------------------------------------------------------------------
`default_nettype none

package shpf_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WIDTH_W     = COL_W + 1;
	localparam int SLICE_COUNT = 15;
	localparam int SLICE_W     = 4;
	localparam int CNT_W       = 8;
	localparam int HEIGHT_W    = 8;
	localparam int ROW_W       = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	// register index, taken from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_SLICE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(32);

	// one classified pixel request, front to back
	typedef struct packed {
		logic                pix;
		logic [COL_W-1:0]    col;
		logic                first_row;
		logic                last_row;
		logic                emit;
		logic [SLICE_W-1:0]  slice;
		logic [ROW_W-1:0]    centre;
	} op_t;

endpackage

`default_nettype wire

// ----- hdl/shpf_front.sv -----
// ----------------------------------------------------------------------------
// shpf_front
// Raster position tracking: column, row in slice and slice index. Classifies
// each pixel and pushes it to the queue until all slices of the frame are done.
// ----------------------------------------------------------------------------
`default_nettype none

module shpf_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic                           pixel_on,
	input  wire logic                           frame_start,
	input  wire logic [shpf_pkg::WIDTH_W-1:0]   width,
	input  wire logic [shpf_pkg::HEIGHT_W-1:0]  height,
	output logic                                push,
	output shpf_pkg::op_t                       push_op
);

	logic [shpf_pkg::COL_W-1:0]    col_q;
	logic [shpf_pkg::HEIGHT_W-1:0] row_q;
	logic [shpf_pkg::SLICE_W-1:0]  slice_q;

	logic [shpf_pkg::COL_W-1:0]    col_eff;
	logic [shpf_pkg::HEIGHT_W-1:0] row_eff;
	logic [shpf_pkg::SLICE_W-1:0]  slice_eff;
	logic                          done;
	logic                          row_end;
	logic                          last_row;
	logic [shpf_pkg::ROW_W-1:0]    centre;

	always_comb begin
		col_eff   = frame_start ? '0 : col_q;
		row_eff   = frame_start ? '0 : row_q;
		slice_eff = frame_start ? '0 : slice_q;
		done      = 32'(slice_eff) >= shpf_pkg::SLICE_COUNT;
		row_end   = {1'b0, col_eff} >= (width - shpf_pkg::WIDTH_W'(1));
		last_row  = row_eff >= (height - shpf_pkg::HEIGHT_W'(1));
		centre    = shpf_pkg::ROW_W'(slice_eff) * shpf_pkg::ROW_W'(height)
			+ shpf_pkg::ROW_W'(height >> 1);
	end

	assign push = accept && !done;

	always_comb begin
		push_op           = '0;
		push_op.pix       = pixel_on;
		push_op.col       = col_eff;
		push_op.first_row = (row_eff == '0);
		push_op.last_row  = last_row;
		push_op.emit      = row_end && last_row;
		push_op.slice     = slice_eff;
		push_op.centre    = centre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
		end else if (accept) begin
			if (done) begin
				col_q   <= col_eff;
				row_q   <= row_eff;
				slice_q <= slice_eff;
			end else if (!row_end) begin
				col_q   <= col_eff + shpf_pkg::COL_W'(1);
				row_q   <= row_eff;
				slice_q <= slice_eff;
			end else if (!last_row) begin
				col_q   <= '0;
				row_q   <= row_eff + shpf_pkg::HEIGHT_W'(1);
				slice_q <= slice_eff;
			end else begin
				col_q   <= '0;
				row_q   <= '0;
				slice_q <= slice_eff + shpf_pkg::SLICE_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/shpf_queue.sv -----
// ----------------------------------------------------------------------------
// shpf_queue
// Short first-in first-out queue of classified pixel requests.
// ----------------------------------------------------------------------------
`default_nettype none

module shpf_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire shpf_pkg::op_t                push_op,
	input  wire logic                         pop,
	output shpf_pkg::op_t                     head,
	output logic                              empty,
	output logic                              full,
	output logic [shpf_pkg::QCNT_W-1:0]       count
);

	shpf_pkg::op_t                 slots_q [shpf_pkg::QUEUE_DEPTH];
	logic [shpf_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [shpf_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [shpf_pkg::QCNT_W-1:0]   count_q;

	assign head  = slots_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == shpf_pkg::QCNT_W'(shpf_pkg::QUEUE_DEPTH));
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + shpf_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + shpf_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + shpf_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - shpf_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/shpf_back.sv -----
// ----------------------------------------------------------------------------
// shpf_back
// Column count memory with read-modify-write, per-half peak search and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module shpf_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           head_avail,
	input  wire shpf_pkg::op_t                  head,
	input  wire logic [shpf_pkg::COL_W-1:0]     middle,
	input  wire logic                           out_stall,
	output logic                                pop,
	output logic                                out_valid,
	output logic [shpf_pkg::SLICE_W-1:0]        slice_number,
	output logic [shpf_pkg::ROW_W-1:0]          centre_row,
	output logic                                left_valid,
	output logic [shpf_pkg::COL_W-1:0]          left_column,
	output logic                                right_valid,
	output logic [shpf_pkg::COL_W-1:0]          right_column
);

	logic [shpf_pkg::CNT_W-1:0] counts_mem [shpf_pkg::MAX_WIDTH];

	logic                        vld_s1;
	shpf_pkg::op_t               op_s1;
	logic [shpf_pkg::CNT_W-1:0]  rdata_s1;
	logic                        fwd_hit_s1;
	logic [shpf_pkg::CNT_W-1:0]  fwd_cnt_s1;

	logic [shpf_pkg::CNT_W-1:0]  l_cnt_q;
	logic [shpf_pkg::COL_W-1:0]  l_col_q;
	logic [shpf_pkg::CNT_W-1:0]  r_cnt_q;
	logic [shpf_pkg::COL_W-1:0]  r_col_q;
	logic                        out_valid_q;

	logic                        fire;
	logic [shpf_pkg::CNT_W-1:0]  base;
	logic [shpf_pkg::CNT_W:0]    sum;
	logic [shpf_pkg::CNT_W-1:0]  cnt;
	logic                        left_side;
	logic                        l_upd;
	logic                        r_upd;
	logic [shpf_pkg::COL_W-1:0]  l_col_nx;
	logic [shpf_pkg::COL_W-1:0]  r_col_nx;
	logic [shpf_pkg::WIDTH_W-1:0] mid_m1;
	logic [shpf_pkg::WIDTH_W-1:0] r_last;

	assign fire = vld_s1 && (!op_s1.emit || !out_valid_q || !out_stall);
	assign pop  = head_avail && (!vld_s1 || fire);

	always_comb begin
		base      = fwd_hit_s1 ? fwd_cnt_s1 : rdata_s1;
		sum       = {1'b0, base} + (shpf_pkg::CNT_W + 1)'(op_s1.pix);
		if (op_s1.first_row) begin
			cnt = shpf_pkg::CNT_W'(op_s1.pix);
		end else if (sum[shpf_pkg::CNT_W]) begin
			cnt = '1;
		end else begin
			cnt = sum[shpf_pkg::CNT_W-1:0];
		end
		left_side = op_s1.col < middle;
		l_upd     = op_s1.last_row && left_side
			&& (op_s1.col == '0 || cnt > l_cnt_q);
		r_upd     = op_s1.last_row && !left_side
			&& (op_s1.col == middle || cnt > r_cnt_q);
		l_col_nx  = l_upd ? op_s1.col : l_col_q;
		r_col_nx  = r_upd ? op_s1.col : r_col_q;
		mid_m1    = {1'b0, middle} - shpf_pkg::WIDTH_W'(1);
		r_last    = {1'b0, middle} + mid_m1;
	end

	// read at pop, write at fire; forward a write that lands on the read edge
	always_ff @(posedge clk) begin
		if (fire) begin
			counts_mem[op_s1.col] <= cnt;
		end
		if (pop) begin
			rdata_s1   <= counts_mem[head.col];
			op_s1      <= head;
			fwd_hit_s1 <= fire && (op_s1.col == head.col);
			fwd_cnt_s1 <= cnt;
		end
		if (fire && op_s1.emit) begin
			slice_number <= op_s1.slice;
			centre_row   <= op_s1.centre;
			left_column  <= l_col_nx;
			left_valid   <= ({1'b0, l_col_nx} != mid_m1) && (l_col_nx != '0);
			right_column <= r_col_nx;
			right_valid  <= ({1'b0, r_col_nx} != r_last) && (r_col_nx != middle);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			l_cnt_q     <= '0;
			l_col_q     <= '0;
			r_cnt_q     <= '0;
			r_col_q     <= '0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire && op_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fire && l_upd) begin
				l_cnt_q <= cnt;
				l_col_q <= op_s1.col;
			end
			if (fire && r_upd) begin
				r_cnt_q <= cnt;
				r_col_q <= op_s1.col;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/slice_histogram_peak_finder.sv -----
// ----------------------------------------------------------------------------
// slice_histogram_peak_finder
// Per-slice column histogram of a binary image with left/right peak search.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the result output is not stalled,
//   set by the single read-modify-write port of the column count memory
//   (a same-column write on the read edge is forwarded).
// Result path: a slice's last accepted pixel passes a queue slot and the
//   memory read register, then the result register sets out_valid.
// Reset: counters, queue, peak trackers and handshakes clear at once; the
//   count memory is not cleared, the first row of every slice overwrites it.
// ----------------------------------------------------------------------------
`default_nettype none

module slice_histogram_peak_finder (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [shpf_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [shpf_pkg::DATA_W-1:0]           pwdata,
	output logic      [shpf_pkg::DATA_W-1:0]           prdata,
	output logic                                       pready,
	// pixel stream
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  pixel_on,
	input  wire logic                                  frame_start,
	// slice results
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [shpf_pkg::SLICE_W-1:0]               slice_number,
	output logic [shpf_pkg::ROW_W-1:0]                 centre_row,
	output logic                                       left_valid,
	output logic [shpf_pkg::COL_W-1:0]                 left_column,
	output logic                                       right_valid,
	output logic [shpf_pkg::COL_W-1:0]                 right_column
);

	logic [shpf_pkg::WIDTH_W-1:0]  image_width_q;
	logic [shpf_pkg::HEIGHT_W-1:0] slice_height_q;

	logic [shpf_pkg::WIDTH_W-1:0]  width;
	logic [shpf_pkg::HEIGHT_W-1:0] height;
	logic [shpf_pkg::COL_W-1:0]    middle;

	logic                          accept;
	logic                          push;
	shpf_pkg::op_t                 push_op;
	shpf_pkg::op_t                 head;
	logic                          q_empty;
	logic                          q_full;
	logic [shpf_pkg::QCNT_W-1:0]   q_count;
	logic                          pop;
	logic                          cfg_wr;

	// register file: index comes from paddr[2], byte offset bits are ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= shpf_pkg::WIDTH_RESET;
			slice_height_q <= shpf_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				shpf_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[shpf_pkg::WIDTH_W-1:0];
				shpf_pkg::REG_SLICE_HEIGHT: slice_height_q <= pwdata[shpf_pkg::HEIGHT_W-1:0];
				default:                    image_width_q  <= image_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			shpf_pkg::REG_IMAGE_WIDTH:  prdata = shpf_pkg::DATA_W'(image_width_q);
			shpf_pkg::REG_SLICE_HEIGHT: prdata = shpf_pkg::DATA_W'(slice_height_q);
			default:                    prdata = '0;
		endcase
	end

	// clamp width to the supported range and treat zero height as one row
	always_comb begin
		if (image_width_q < shpf_pkg::WIDTH_W'(2)) begin
			width = shpf_pkg::WIDTH_W'(2);
		end else if (image_width_q > shpf_pkg::WIDTH_W'(shpf_pkg::MAX_WIDTH)) begin
			width = shpf_pkg::WIDTH_W'(shpf_pkg::MAX_WIDTH);
		end else begin
			width = image_width_q;
		end
		height = (slice_height_q == '0) ? shpf_pkg::HEIGHT_W'(1) : slice_height_q;
		middle = width[shpf_pkg::WIDTH_W-1:1];
	end

	// hold the pixel stream whenever the queue is full
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	shpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel_on    (pixel_on),
		.frame_start (frame_start),
		.width       (width),
		.height      (height),
		.push        (push),
		.push_op     (push_op)
	);

	shpf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full),
		.count   (q_count)
	);

	shpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_avail   (!q_empty),
		.head         (head),
		.middle       (middle),
		.out_stall    (out_stall),
		.pop          (pop),
		.out_valid    (out_valid),
		.slice_number (slice_number),
		.centre_row   (centre_row),
		.left_valid   (left_valid),
		.left_column  (left_column),
		.right_valid  (right_valid),
		.right_column (right_column)
	);

	// back end never drains an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_count != '0)
		else $error("pop from empty queue");

	// queue count rises by one after a push without a pop
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> q_count == $past(q_count) + shpf_pkg::QCNT_W'(1))
		else $error("queue count out of step");

	// a result always names a slice inside the frame
	a_slice_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(slice_number) < shpf_pkg::SLICE_COUNT)
		else $error("result slice index out of range");

	// hold a stalled result and its fields until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid
			&& $stable({slice_number, centre_row, left_valid, left_column,
			            right_valid, right_column}))
		else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- sim/slice_histogram_peak_finder_test.sv -----
// ----------------------------------------------------------------------------
// slice_histogram_peak_finder_test
// Streams binary images through the slice histogram peak finder and checks
// every slice result against a cycle-free software model of the per-column
// counts and left/right peak search. Register settings change between phases,
// both handshakes idle at random, and one long output hold fills the block.
// ----------------------------------------------------------------------------

module slice_histogram_peak_finder_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 600_000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_PIXELS = 200;
	localparam int FRAME_BUDGET  = 400;

	// one pixel request as offered on the input channel
	typedef struct packed {
		logic pix;
		logic fs;
	} pixel_t;

	// one slice result, field order as on the output ports
	typedef struct packed {
		logic [shpf_pkg::SLICE_W-1:0] slice;
		logic [shpf_pkg::ROW_W-1:0]   centre;
		logic                         lv;
		logic [shpf_pkg::COL_W-1:0]   lc;
		logic                         rv;
		logic [shpf_pkg::COL_W-1:0]   rc;
	} peak_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [shpf_pkg::ADDR_W-1:0] paddr   = '0;
	logic [shpf_pkg::DATA_W-1:0] pwdata  = '0;
	logic [shpf_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	logic in_valid    = 1'b0;
	logic in_stall;
	logic pixel_on    = 1'b0;
	logic frame_start = 1'b0;

	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [shpf_pkg::SLICE_W-1:0] slice_number;
	logic [shpf_pkg::ROW_W-1:0]   centre_row;
	logic                         left_valid;
	logic [shpf_pkg::COL_W-1:0]   left_column;
	logic                         right_valid;
	logic [shpf_pkg::COL_W-1:0]   right_column;

	// shadow of the configuration registers
	logic [shpf_pkg::WIDTH_W-1:0]  cfg_width  = shpf_pkg::WIDTH_RESET;
	logic [shpf_pkg::HEIGHT_W-1:0] cfg_height = shpf_pkg::HEIGHT_RESET;

	// shadow of the block's histogram state
	logic [shpf_pkg::CNT_W-1:0]    hist [shpf_pkg::MAX_WIDTH];
	logic [shpf_pkg::COL_W-1:0]    col_pos   = '0;
	logic [shpf_pkg::HEIGHT_W-1:0] row_pos   = '0;
	logic [shpf_pkg::SLICE_W-1:0]  slice_idx = '0;
	logic [shpf_pkg::CNT_W-1:0]    left_cnt  = '0;
	logic [shpf_pkg::COL_W-1:0]    left_col  = '0;
	logic [shpf_pkg::CNT_W-1:0]    right_cnt = '0;
	logic [shpf_pkg::COL_W-1:0]    right_col = '0;

	pixel_t pixel_q [$];
	peak_t  peaks_due [$];
	pixel_t next_req;
	peak_t  predicted;
	peak_t  want;
	peak_t  seen;

	int pixels_queued = 0;
	int pixels_taken  = 0;
	int bad_results   = 0;
	int cycle_count   = 0;
	int send_gap      = 0;
	int stall_gap     = 0;
	int hold_cycles   = 0;
	logic calm        = 1'b0;
	logic hold_start  = 1'b0;

	slice_histogram_peak_finder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_on     (pixel_on),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slice_number (slice_number),
		.centre_row   (centre_row),
		.left_valid   (left_valid),
		.left_column  (left_column),
		.right_valid  (right_valid),
		.right_column (right_column)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamp the width register into the supported histogram span.
	function automatic int span_of(input logic [shpf_pkg::WIDTH_W-1:0] raw);
		if (raw < 2)
			return 2;
		if (raw > shpf_pkg::MAX_WIDTH)
			return shpf_pkg::MAX_WIDTH;
		return int'(raw);
	endfunction

	// A zero slice height behaves as one row.
	function automatic int rows_of(input logic [shpf_pkg::HEIGHT_W-1:0] raw);
		return (raw == 0) ? 1 : int'(raw);
	endfunction

	// Advance the histogram shadow by one accepted pixel; return 1 and the
	// slice result when this pixel closes a slice.
	function automatic bit track_pixel(input logic pix, input logic fs, output peak_t res);
		int span;
		int rows;
		int middle;
		int col;
		logic [shpf_pkg::CNT_W:0] tally;
		logic last_row;
		int unsigned rel;
		int unsigned centre;
		res = '0;
		span = span_of(cfg_width);
		rows = rows_of(cfg_height);
		middle = span / 2;
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
			slice_idx = '0;
		end
		// frame done: drop pixels until the next frame start
		if (slice_idx >= shpf_pkg::SLICE_COUNT)
			return 1'b0;
		col = int'(col_pos);
		// first row of a slice overwrites, later rows accumulate and saturate
		if (row_pos == 0) begin
			tally = (shpf_pkg::CNT_W + 1)'(pix);
		end else begin
			tally = (shpf_pkg::CNT_W + 1)'(hist[col]) + (shpf_pkg::CNT_W + 1)'(pix);
			if (tally > {1'b0, {shpf_pkg::CNT_W{1'b1}}})
				tally = {1'b0, {shpf_pkg::CNT_W{1'b1}}};
		end
		hist[col] = tally[shpf_pkg::CNT_W-1:0];
		last_row = row_pos >= rows - 1;
		// peak search runs on the slice's last row, first maximum wins
		if (last_row) begin
			if (col < middle) begin
				if (col == 0 || tally > left_cnt) begin
					left_cnt = tally[shpf_pkg::CNT_W-1:0];
					left_col = shpf_pkg::COL_W'(col);
				end
			end else if (col == middle || tally > right_cnt) begin
				right_cnt = tally[shpf_pkg::CNT_W-1:0];
				right_col = shpf_pkg::COL_W'(col);
			end
		end
		if (col_pos < span - 1) begin
			col_pos++;
			return 1'b0;
		end
		col_pos = '0;
		if (!last_row) begin
			row_pos++;
			return 1'b0;
		end
		// wraps like the hardware when the right peak sits left of the middle
		rel = right_col - middle;
		centre = slice_idx * rows + rows / 2;
		res.slice = slice_idx;
		res.centre = shpf_pkg::ROW_W'(centre);
		res.lv = (left_col != middle - 1) && (left_col != 0);
		res.lc = left_col;
		res.rv = (rel != middle - 1) && (rel != 0);
		res.rc = right_col;
		row_pos = '0;
		slice_idx++;
		return 1'b1;
	endfunction

	// Queue n pixels, leftmost column from bits[n-1]; fs marks the first one.
	function automatic void queue_bits(input logic [15:0] bits, input int n, input bit fs);
		for (int i = n - 1; i >= 0; i--)
			pixel_q.insert(pixel_q.size(), {bits[i], fs && i == n - 1});
		pixels_queued += n;
	endfunction

	// Queue a frame of whole slices with two lane columns that light up
	// often over a random background; a ragged frame stops at a random pixel.
	function automatic int queue_frame(input int wd, input int ht, input int slices,
	                                   input bit start, input bit ragged);
		int total;
		int lane_l;
		int lane_r;
		int dens;
		int col;
		logic pix;
		total = wd * ht * slices;
		if (ragged)
			total = $urandom_range(1, total);
		lane_l = $urandom_range(0, wd / 2 - 1);
		lane_r = $urandom_range(wd / 2, wd - 1);
		dens = $urandom_range(0, 16);
		for (int i = 0; i < total; i++) begin
			col = i % wd;
			if (col == lane_l || col == lane_r)
				pix = $urandom_range(0, 3) != 0;
			else
				pix = $urandom_range(1, 16) <= dens;
			pixel_q.insert(pixel_q.size(), {pix, start && i == 0});
		end
		pixels_queued += total;
		return total;
	endfunction

	// One APB write: setup cycle, then access until pready.
	task automatic write_reg(input logic [shpf_pkg::ADDR_W-1:0] addr,
	                         input logic [shpf_pkg::DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write both registers with junk in the unused upper bits.
	task automatic set_regs(input int raw_w, input int raw_h);
		write_reg({shpf_pkg::REG_IMAGE_WIDTH, 2'b00},
		          {21'($urandom), shpf_pkg::WIDTH_W'(raw_w)});
		write_reg({shpf_pkg::REG_SLICE_HEIGHT, 2'b00},
		          {24'($urandom), shpf_pkg::HEIGHT_W'(raw_h)});
		cfg_width = shpf_pkg::WIDTH_W'(raw_w);
		cfg_height = shpf_pkg::HEIGHT_W'(raw_h);
	endtask

	// Hold the sender until every request is taken and every slice result is
	// back, then let the pipeline settle before touching the registers.
	task automatic drain();
		do @(posedge clk);
		while (pixels_taken != pixels_queued || peaks_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: offer queued pixel requests, hold a stalled one, idle in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_on <= 1'b0;
			frame_start <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				pixels_taken++;
				if (track_pixel(pixel_on, frame_start, predicted))
					peaks_due.insert(peaks_due.size(), predicted);
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (!calm && pixel_q.size() != 0 && $urandom_range(0, 11) == 0) begin
					// idle burst: drop the request and count down a random gap
					in_valid <= 1'b0;
					send_gap <= $urandom_range(0, 17);
				end else if (pixel_q.size() != 0) begin
					next_req = pixel_q.pop_front();
					in_valid <= 1'b1;
					pixel_on <= next_req.pix;
					frame_start <= next_req.fs;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted apart from the random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
		end else if (hold_start) begin
			hold_cycles <= LONG_HOLD;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Monitor: check each accepted slice result, stall in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {slice_number, centre_row, left_valid, left_column,
				        right_valid, right_column};
				if (peaks_due.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("unexpected slice result: slice %0d centre %0d left %b/%0d right %b/%0d",
						         seen.slice, seen.centre, seen.lv, seen.lc, seen.rv, seen.rc);
				end else begin
					want = peaks_due.pop_front();
					if (seen !== want) begin
						bad_results++;
						if (bad_results <= 10) begin
							$display("slice result mismatch at cycle %0d", cycle_count);
							$display("  expected slice %0d centre %0d left %b/%0d right %b/%0d",
							         want.slice, want.centre, want.lv, want.lc, want.rv, want.rc);
							$display("  actual   slice %0d centre %0d left %b/%0d right %b/%0d",
							         seen.slice, seen.centre, seen.lv, seen.lc, seen.rv, seen.rc);
						end
					end
				end
			end
			if (hold_cycles != 0) begin
				out_stall <= 1'b1;
			end else if (stall_gap != 0) begin
				out_stall <= 1'b1;
				stall_gap <= stall_gap - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				stall_gap <= $urandom_range(0, 17);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("slice_histogram_peak_finder_test: done, errors");
			$finish;
		end
	end

	initial begin
		int raw_w;
		int raw_h;
		int wd;
		int ht;
		int fit;
		int slices;
		int frames;
		int random_pixels;
		bit ragged;
		random_pixels = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Narrowest image, zero height: width below two and height zero both
		// clamp; run all fifteen slices, then pixels past the frame are dropped
		// until a new frame start.
		set_regs(0, 0);
		for (int s = 0; s < shpf_pkg::SLICE_COUNT; s++)
			queue_bits(16'(s), 2, s == 0);
		queue_bits(16'b111, 3, 1'b0);
		queue_bits(16'b11, 2, 1'b1);
		drain();

		// Six columns, two rows: valid peaks inside each half, ties that pick
		// the first column, and a frame start in the middle of a row.
		set_regs(6, 2);
		queue_bits(16'b010010, 6, 1'b1);
		queue_bits(16'b011011, 6, 1'b0);
		queue_bits(16'b111111, 6, 1'b0);
		queue_bits(16'b111111, 6, 1'b0);
		queue_bits(16'b000, 3, 1'b0);
		queue_bits(16'b001001, 6, 1'b1);
		queue_bits(16'b001001, 6, 1'b0);
		drain();

		// Oversized width clamps to the full span; this row also writes every
		// count entry once, so later register changes mid-slice stay defined.
		set_regs(2047, 1);
		void'(queue_frame(shpf_pkg::MAX_WIDTH, 1, 1, 1'b1, 1'b0));
		drain();

		// Tallest slice on the narrowest image, then stop partway into the
		// next slice so the following phase changes registers mid-slice.
		set_regs(2, 255);
		void'(queue_frame(2, 255, 1, 1'b1, 1'b0));
		void'(queue_frame(2, 5, 1, 1'b0, 1'b0));
		drain();

		// Dense results with the receiver held off for a long stretch: the
		// pixel queue fills and the block must stall its input.
		set_regs(3, 1);
		for (int f = 0; f < 3; f++)
			void'(queue_frame(3, 1, shpf_pkg::SLICE_COUNT, f != 0, 1'b0));
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		drain();

		// Random settings, mostly small images with well-formed frames; some
		// frames are cut short and some phases continue the previous frame.
		// Both sides stop idling here to close the run.
		while (random_pixels < RANDOM_PIXELS) begin
			calm <= 1'b1;
			case ($urandom_range(0, 9))
				0: raw_w = $urandom_range(0, 3);
				1, 2: raw_w = $urandom_range(25, 200);
				default: raw_w = $urandom_range(4, 24);
			endcase
			case ($urandom_range(0, 7))
				0: raw_h = $urandom_range(0, 1);
				1: raw_h = $urandom_range(6, 40);
				default: raw_h = $urandom_range(1, 4);
			endcase
			if (span_of(shpf_pkg::WIDTH_W'(raw_w)) * rows_of(shpf_pkg::HEIGHT_W'(raw_h))
			    > FRAME_BUDGET)
				raw_h = $urandom_range(0, 2);
			set_regs(raw_w, raw_h);
			wd = span_of(shpf_pkg::WIDTH_W'(raw_w));
			ht = rows_of(shpf_pkg::HEIGHT_W'(raw_h));
			fit = FRAME_BUDGET / (wd * ht);
			if (fit > shpf_pkg::SLICE_COUNT)
				fit = shpf_pkg::SLICE_COUNT;
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames && random_pixels < RANDOM_PIXELS; f++) begin
				slices = ($urandom_range(0, 2) == 0) ? fit : $urandom_range(1, fit);
				ragged = $urandom_range(0, 7) == 0;
				random_pixels += queue_frame(wd, ht, slices,
				                             f != 0 || $urandom_range(0, 3) != 0, ragged);
				// trail a few pixels past a finished frame
				if (slices == shpf_pkg::SLICE_COUNT && !ragged)
					repeat ($urandom_range(1, 3))
						queue_bits(16'($urandom_range(0, 1)), 1, 1'b0);
			end
			drain();
		end

		if (bad_results == 0) begin
			$display("slice_histogram_peak_finder_test: done, clean");
		end else begin
			$display("slice_histogram_peak_finder_test: done, errors");
		end
		$finish;
	end

endmodule
